// ----- rtl/tgpr_pkg.sv -----
`default_nettype none

package tgpr_pkg;

	localparam int DEF_SCREEN_WIDTH  = 240;
	localparam int DEF_SCREEN_HEIGHT = 320;

	localparam logic [7:0]  NEWLINE_CODE   = 8'd10;
	localparam logic [7:0]  FIRST_DRAWABLE = 8'd32;
	localparam logic [7:0]  LAST_DRAWABLE  = 8'd127;
	localparam logic [15:0] LINE_PITCH     = 16'd10;
	localparam logic [15:0] GLYPH_ADVANCE  = 16'd8;
	localparam int          GLYPH_SIZE     = 8;

	typedef struct packed {
		logic [7:0]  char_code;
		logic        string_start;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [15:0] fg_color;
		logic [15:0] back_color;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  pixel_x;
		logic [8:0]  pixel_y;
		logic [15:0] pixel_color;
		logic        last_pixel;
	} pixel_t;

	// One character handed from the cursor logic to the raster unit.
	typedef struct packed {
		logic [6:0]  code;
		logic [15:0] col;
		logic [15:0] row;
		logic [7:0]  col_vis;
		logic [7:0]  row_vis;
		logic [15:0] fg;
		logic [15:0] bg;
	} job_t;

	// Whole 8x8 glyph, top row in the high byte, MSB is the leftmost column.
	function automatic logic [63:0] glyph_bits(input logic [6:0] code);
		logic [63:0] g;
		case (code)
			7'd48:  g = 64'h3C666E7666663C00;
			7'd49:  g = 64'h1838181818187E00;
			7'd50:  g = 64'h3C66060C18307E00;
			7'd51:  g = 64'h3C66061C06663C00;
			7'd52:  g = 64'h0C1C2C4C7E0C0C00;
			7'd53:  g = 64'h7E607C0606663C00;
			7'd54:  g = 64'h1C30607C66663C00;
			7'd55:  g = 64'h7E060C1830303000;
			7'd56:  g = 64'h3C66663C66663C00;
			7'd57:  g = 64'h3C66663E060C3800;
			7'd65:  g = 64'h183C66667E666600;
			7'd66:  g = 64'h7C66667C66667C00;
			7'd67:  g = 64'h3C66606060663C00;
			7'd68:  g = 64'h786C6666666C7800;
			7'd69:  g = 64'h7E60607860607E00;
			7'd70:  g = 64'h7E60607860606000;
			7'd71:  g = 64'h3C66606E66663C00;
			7'd72:  g = 64'h6666667E66666600;
			7'd73:  g = 64'h3C18181818183C00;
			7'd74:  g = 64'h1E0C0C0C0C6C3800;
			7'd75:  g = 64'h666C7870786C6600;
			7'd76:  g = 64'h6060606060607E00;
			7'd77:  g = 64'h63777F6B63636300;
			7'd78:  g = 64'h66767E7E6E666600;
			7'd79:  g = 64'h3C66666666663C00;
			7'd80:  g = 64'h7C66667C60606000;
			7'd81:  g = 64'h3C666666663C0E00;
			7'd82:  g = 64'h7C66667C786C6600;
			7'd83:  g = 64'h3C66603C06663C00;
			7'd84:  g = 64'h7E18181818181800;
			7'd85:  g = 64'h6666666666663C00;
			7'd86:  g = 64'h66666666663C1800;
			7'd87:  g = 64'h6363636B7F776300;
			7'd88:  g = 64'h66663C183C666600;
			7'd89:  g = 64'h6666663C18181800;
			7'd90:  g = 64'h7E060C1830607E00;
			7'd97:  g = 64'h00003C063E663E00;
			7'd98:  g = 64'h60607C6666667C00;
			7'd99:  g = 64'h00003C6060603C00;
			7'd100: g = 64'h06063E6666663E00;
			7'd101: g = 64'h00003C667E603C00;
			7'd102: g = 64'h0E18183E18181800;
			7'd103: g = 64'h00003E66663E067C;
			7'd104: g = 64'h60607C6666666600;
			7'd105: g = 64'h1800381818183C00;
			7'd106: g = 64'h060006060606663C;
			7'd107: g = 64'h60606C786C666600;
			7'd108: g = 64'h3818181818183C00;
			7'd109: g = 64'h0000667F7F6B6300;
			7'd110: g = 64'h00007C6666666600;
			7'd111: g = 64'h00003C6666663C00;
			7'd112: g = 64'h00007C66667C6060;
			7'd113: g = 64'h00003E66663E0606;
			7'd114: g = 64'h00007C6660606000;
			7'd115: g = 64'h00003E603C067C00;
			7'd116: g = 64'h18187E1818180E00;
			7'd117: g = 64'h0000666666663E00;
			7'd118: g = 64'h00006666663C1800;
			7'd119: g = 64'h0000636B7F3E3600;
			7'd120: g = 64'h0000663C183C6600;
			7'd121: g = 64'h00006666663E0C78;
			7'd122: g = 64'h00007E0C18307E00;
			default: g = 64'h0;
		endcase
		return g;
	endfunction

	// Font ROM word: address is {code, glyph row}.
	function automatic logic [7:0] font_row(input logic [9:0] addr);
		logic [63:0] g;
		g = glyph_bits(addr[9:3]);
		return g[(7 - int'(addr[2:0])) * 8 +: 8];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/tgpr_raster.sv -----
`default_nettype none

module tgpr_raster
	import tgpr_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   job_load,
	input  wire job_t   job,
	output logic        load_ok,
	output logic        out_valid,
	input  wire logic   out_ready,
	output pixel_t      out_item
);

	logic        busy_q;
	logic [5:0]  idx_q;
	job_t        job_q;

	logic        s1_valid;
	logic [7:0]  s1_x;
	logic [8:0]  s1_y;
	logic [2:0]  s1_c;
	logic        s1_last;
	logic [15:0] s1_fg;
	logic [15:0] s1_bg;
	logic [7:0]  rom_s1;

	logic        out_valid_q;
	pixel_t      out_q;

	logic        adv;
	logic        step;
	logic        last_step;
	logic [2:0]  r;
	logic [2:0]  c;
	logic        vis;
	logic        is_last;
	logic [9:0]  rom_addr;

	always_comb begin
		adv       = !out_valid_q || out_ready;
		step      = busy_q && adv;
		last_step = step && (&idx_q);
		load_ok   = !busy_q || last_step;
		r         = idx_q[5:3];
		c         = idx_q[2:0];
		vis       = job_q.col_vis[c] && job_q.row_vis[r];
		is_last   = ((job_q.col_vis >> c) >> 1) == 8'd0 && ((job_q.row_vis >> r) >> 1) == 8'd0;
		rom_addr  = {job_q.code, r};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 6'd0;
		end else if (job_load) begin
			busy_q <= 1'b1;
			idx_q  <= 6'd0;
		end else if (last_step) begin
			busy_q <= 1'b0;
		end else if (step) begin
			idx_q <= idx_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			job_q <= job;
		end
	end

	// Font ROM: registered read, lines up with stage 1.
	always_ff @(posedge clk) begin
		if (step) begin
			rom_s1 <= font_row(rom_addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid    <= step && vis;
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_x    <= job_q.col[7:0] + {5'd0, c};
			s1_y    <= job_q.row[8:0] + {6'd0, r};
			s1_c    <= c;
			s1_last <= is_last;
			s1_fg   <= job_q.fg;
			s1_bg   <= job_q.bg;
			out_q.pixel_x     <= s1_x;
			out_q.pixel_y     <= s1_y;
			out_q.pixel_color <= rom_s1[3'd7 - s1_c] ? s1_fg : s1_bg;
			out_q.last_pixel  <= s1_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// ----- rtl/text_glyph_pixel_renderer.sv -----
// Pipeline: an accepted character is held in the job register, then each glyph position
// passes stage 1 (font ROM read) and the output register.
// Throughput: one pixel per cycle while out_ready is high, none for clipped positions; a
// drawable character steps the font ROM once per glyph position, clipped ones included; the
// next is taken in its last step; newline and undrawable codes just move the cursor.
// Reset: arst_n clears the cursor, line start and all valid flags asynchronously.
`default_nettype none

module text_glyph_pixel_renderer
	import tgpr_pkg::*;
#(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	output logic          out_valid,
	input  wire logic     out_ready,
	output pixel_t        out_item
);

	localparam logic [15:0] WRAP_COL = 16'(SCREEN_WIDTH - GLYPH_SIZE);
	localparam logic [15:0] SCR_W    = 16'(SCREEN_WIDTH);
	localparam logic [15:0] SCR_H    = 16'(SCREEN_HEIGHT);

	// Text cursor state.
	logic [15:0] cursor_col_q;
	logic [15:0] cursor_row_q;
	logic [15:0] line_start_q;

	logic        accept;
	logic        load_ok;
	logic        drawable;
	logic        newline;
	logic [15:0] cur_col;
	logic [15:0] cur_row;
	logic [15:0] cur_ls;
	logic [15:0] adv_col;
	logic [15:0] next_col;
	logic [15:0] next_row;
	logic [15:0] col_sum;
	logic [15:0] row_sum;
	job_t        job;

	always_comb begin
		accept   = in_valid && in_ready;
		newline  = in_item.char_code == NEWLINE_CODE;
		drawable = in_item.char_code >= FIRST_DRAWABLE && in_item.char_code <= LAST_DRAWABLE;

		// Apply the string origin before anything else.
		cur_col = in_item.string_start ? in_item.origin_x : cursor_col_q;
		cur_row = in_item.string_start ? in_item.origin_y : cursor_row_q;
		cur_ls  = in_item.string_start ? in_item.origin_x : line_start_q;

		adv_col = cur_col + GLYPH_ADVANCE;
		if (newline || adv_col >= WRAP_COL) begin
			// Return to the line start one text line down.
			next_col = cur_ls;
			next_row = cur_row + LINE_PITCH;
		end else begin
			next_col = adv_col;
			next_row = cur_row;
		end

		// Visibility of each glyph column and row after the 16-bit wrap.
		job.code = in_item.char_code[6:0];
		job.col  = cur_col;
		job.row  = cur_row;
		job.fg   = in_item.fg_color;
		job.bg   = in_item.back_color;
		for (int i = 0; i < GLYPH_SIZE; i++) begin
			col_sum        = cur_col + 16'(i);
			row_sum        = cur_row + 16'(i);
			job.col_vis[i] = col_sum < SCR_W;
			job.row_vis[i] = row_sum < SCR_H;
		end
	end

	// Take a new character only when the raster unit can load it.
	assign in_ready = load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= 16'd0;
			cursor_row_q <= 16'd0;
			line_start_q <= 16'd0;
		end else if (accept) begin
			cursor_col_q <= next_col;
			cursor_row_q <= next_row;
			line_start_q <= cur_ls;
		end
	end

	// Glyph walk, font ROM and pixel output register.
	tgpr_raster u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_load  (accept && drawable),
		.job       (job),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

// ----- rtl/tgpr_checker.sv -----
`default_nettype none

module tgpr_checker
	import tgpr_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_ready,
	input wire in_item_t in_item,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire pixel_t   out_item
);

	logic       in_acc;
	logic       out_acc;
	logic [5:0] pix_cnt_q;
	logic [7:0] pend_q;
	logic       sat_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Count pixels of the current character and characters not yet closed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cnt_q <= 6'd0;
			pend_q    <= 8'd0;
			sat_q     <= 1'b0;
		end else begin
			if (out_acc) begin
				pix_cnt_q <= out_item.last_pixel ? 6'd0 : pix_cnt_q + 6'd1;
			end
			if (&pend_q) begin
				sat_q <= 1'b1;
			end
			pend_q <= pend_q + 8'(in_acc && !(&pend_q))
				- 8'(out_acc && out_item.last_pixel && pend_q != 8'd0);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("pixel changed while stalled");

	a_last_by_64: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && pix_cnt_q == 6'd63 |-> out_item.last_pixel)
		else $error("character ran past 64 pixels");

	a_last_has_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_item.last_pixel && !sat_q |-> pend_q != 8'd0)
		else $error("last pixel without a character");

endmodule

bind text_glyph_pixel_renderer tgpr_checker u_tgpr_checker (.*);

`default_nettype wire
